>>> hdl/assert_macros.svh
// Assertion macros used by the checker file emrq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, idle while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check on clk that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/emrq_pkg.sv
// Shared types and constants of the evicting message ring queue.
package emrq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_ENQ    = 3'd1,
		OP_POP    = 3'd2,
		OP_SORT   = 3'd3,
		OP_ROTATE = 3'd4,
		OP_SEARCH = 3'd5,
		OP_PEEK   = 3'd6
	} op_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] prop;
		logic [31:0] payload;
	} rec_t;

endpackage

>>> hdl/emrq_ram.sv
// Ring storage: one write port, one read port with registered read data.
module emrq_ram #(
	parameter int DEPTH = emrq_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  emrq_pkg::rec_t           wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output emrq_pkg::rec_t           rdata
);

	emrq_pkg::rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/evicting_message_ring_queue_top.sv
// Top level of the evicting message ring queue: sequencer, ring pointers and result registers.
//
// Usage:
//   Drive operation and the msg_* fields and raise start; the item is taken
//   at a rising edge where start is high and busy is low. Exactly one result
//   follows, shown for one cycle with done high; occupancy always shows the
//   current record count and is valid with done.
//   Clear, enqueue, an unused code, and pop/peek/rotate/search/sort that
//   find nothing to do complete straight from idle. Pop, peek and rotate
//   first wait for one registered read of the ring memory. Search reads
//   one entry per cycle until a hit or the last record. Sort compares
//   each pair with one read from the single memory read port.
//   A new item may be accepted in the same cycle done is high, so the
//   fastest ops sustain one item per cycle; pop/peek/rotate, search and sort hold busy until their result.
//   The receiver cannot stall: done lasts exactly one cycle.
//   Reset clears count and sets front to 1, rear to 0; ring contents are
//   left as they are and are only read after being written.
module evicting_message_ring_queue_top #(
	parameter int QUEUE_DEPTH = emrq_pkg::DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [2:0]                       operation,
	input  logic [31:0]                      msg_seq,
	input  logic [15:0]                      msg_prop,
	input  logic [31:0]                      msg_payload,
	output logic                             done,
	output logic [31:0]                      out_seq,
	output logic [15:0]                      out_prop,
	output logic [31:0]                      out_payload,
	output logic                             out_valid,
	output logic                             found,
	output logic                             evicted,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_POP  = 8'b0000_0010,
		ST_PEEK = 8'b0000_0100,
		ST_ROT  = 8'b0000_1000,
		ST_SWA  = 8'b0001_0000,
		ST_SCB  = 8'b0010_0000,
		ST_SWB  = 8'b0100_0000,
		ST_QC   = 8'b1000_0000
	} state_t;

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + IDX_W'(1);
	endfunction

	state_t state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d, rear_q, rear_d;
	logic [IDX_W-1:0] pa_q, pa_d, pb_q, pb_d;
	logic [CNT_W-1:0] count_q, count_d, a_q, a_d, b_q, b_d;
	logic             done_q, done_d;
	emrq_pkg::rec_t   cur_q, cur_d;
	logic [31:0]      key_q, key_d;
	emrq_pkg::rec_t   res_q, res_d;
	logic             valid_q, valid_d, found_q, found_d, evicted_q, evicted_d;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	emrq_pkg::rec_t   wdata, rdata, in_rec;

	assign in_rec = '{seq: msg_seq, prop: msg_prop, payload: msg_payload};

	emrq_ram #(.DEPTH(QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		rear_d    = rear_q;
		count_d   = count_q;
		pa_d      = pa_q;
		pb_d      = pb_q;
		a_d       = a_q;
		b_d       = b_q;
		cur_d     = cur_q;
		key_d     = key_q;
		done_d    = 1'b0;
		res_d     = '0;
		valid_d   = 1'b0;
		found_d   = 1'b0;
		evicted_d = 1'b0;
		we        = 1'b0;
		waddr     = rear_q;
		wdata     = in_rec;
		raddr     = front_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_d = msg_seq;
					case (operation)
						emrq_pkg::OP_CLEAR: begin
							count_d = '0;
							front_d = IDX_W'(1);
							rear_d  = '0;
							done_d  = 1'b1;
						end
						emrq_pkg::OP_ENQ: begin
							if (count_q == FULL_CNT) begin
								front_d   = nxt(front_q);
								evicted_d = 1'b1;
							end else begin
								count_d = count_q + CNT_W'(1);
							end
							rear_d = nxt(rear_q);
							we     = 1'b1;
							waddr  = nxt(rear_q);
							wdata  = in_rec;
							done_d = 1'b1;
						end
						emrq_pkg::OP_POP, emrq_pkg::OP_PEEK, emrq_pkg::OP_ROTATE: begin
							if (count_q == '0) begin
								done_d = 1'b1;
							end else if (operation == emrq_pkg::OP_POP) begin
								state_d = ST_POP;
							end else if (operation == emrq_pkg::OP_PEEK) begin
								state_d = ST_PEEK;
							end else begin
								state_d = ST_ROT;
							end
						end
						emrq_pkg::OP_SORT: begin
							if (count_q < CNT_W'(2)) begin
								done_d = 1'b1;
							end else begin
								pa_d    = front_q;
								a_d     = '0;
								state_d = ST_SWA;
							end
						end
						emrq_pkg::OP_SEARCH: begin
							if (count_q == '0) begin
								done_d = 1'b1;
							end else begin
								pb_d    = front_q;
								b_d     = '0;
								state_d = ST_QC;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				res_d   = rdata;
				valid_d = 1'b1;
				count_d = count_q - CNT_W'(1);
				front_d = nxt(front_q);
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_PEEK: begin
				res_d   = rdata;
				valid_d = 1'b1;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_ROT: begin
				we      = 1'b1;
				waddr   = nxt(rear_q);
				wdata   = rdata;
				rear_d  = nxt(rear_q);
				front_d = nxt(front_q);
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SWA: begin
				cur_d   = rdata;
				pb_d    = nxt(pa_q);
				b_d     = a_q + CNT_W'(1);
				raddr   = nxt(pa_q);
				state_d = ST_SCB;
			end
			ST_SCB: begin
				if (rdata.prop > cur_q.prop) begin
					we    = 1'b1;
					waddr = pb_q;
					wdata = cur_q;
					cur_d = rdata;
				end
				if ((CNT_W+1)'(b_q) + (CNT_W+1)'(1) < (CNT_W+1)'(count_q)) begin
					pb_d  = nxt(pb_q);
					b_d   = b_q + CNT_W'(1);
					raddr = nxt(pb_q);
				end else begin
					state_d = ST_SWB;
				end
			end
			ST_SWB: begin
				we    = 1'b1;
				waddr = pa_q;
				wdata = cur_q;
				if ((CNT_W+1)'(a_q) + (CNT_W+1)'(2) < (CNT_W+1)'(count_q)) begin
					pa_d    = nxt(pa_q);
					a_d     = a_q + CNT_W'(1);
					raddr   = nxt(pa_q);
					state_d = ST_SWA;
				end else begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_QC: begin
				if (rdata.seq == key_q) begin
					found_d = 1'b1;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else if ((CNT_W+1)'(b_q) + (CNT_W+1)'(1) < (CNT_W+1)'(count_q)) begin
					pb_d  = nxt(pb_q);
					b_d   = b_q + CNT_W'(1);
					raddr = nxt(pb_q);
				end else begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= IDX_W'(1);
			rear_q  <= '0;
			count_q <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
			pa_q    <= pa_d;
			pb_q    <= pb_d;
			a_q     <= a_d;
			b_q     <= b_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_d;
		key_q     <= key_d;
		res_q     <= res_d;
		valid_q   <= valid_d;
		found_q   <= found_d;
		evicted_q <= evicted_d;
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign out_seq     = res_q.seq;
	assign out_prop    = res_q.prop;
	assign out_payload = res_q.payload;
	assign out_valid   = valid_q;
	assign found       = found_q;
	assign evicted     = evicted_q;
	assign occupancy   = count_q;

endmodule

>>> hdl/emrq_checker.sv
// Port-level checks of the ring queue top level, bound to it.
`include "assert_macros.svh"

module emrq_checker #(
	parameter int QUEUE_DEPTH = emrq_pkg::DEPTH_DEFAULT
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic [2:0]                       operation,
	input logic                             done,
	input logic                             out_valid,
	input logic                             found,
	input logic                             evicted,
	input logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_OCC = CNT_W'(QUEUE_DEPTH);

	logic             enq_take;
	logic [CNT_W-1:0] occ_next;

	assign enq_take = start && !busy && (operation == emrq_pkg::OP_ENQ) && (occupancy != FULL_OCC);
	assign occ_next = occupancy + CNT_W'(1);

	`ASSERT_CLK(a_done_idle, done |-> !busy, "result shown while busy")
	`ASSERT_CLK_ALWAYS(a_occ_bound, !arst_n || (occupancy <= FULL_OCC), "occupancy above depth")
	`ASSERT_CLK(a_flags_strobed, (out_valid || found || evicted) |-> done, "flag without strobe")
	`ASSERT_CLK(a_evict_full, evicted |-> (occupancy == FULL_OCC), "eviction while not full")
	`ASSERT_CLK(a_enq_grow, enq_take |=> (done && occupancy == $past(occ_next)), "enqueue lost")

endmodule

bind evicting_message_ring_queue_top emrq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_emrq_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the evicting message ring queue: directed table, then random episodes.
module tb;

	localparam int DEPTH = emrq_pkg::DEPTH_DEFAULT;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int RAND_ITEMS = 1750;
	localparam int PLAN_LEN = 24;
	localparam int TAIL_CYCLES = 200;

	typedef struct packed {
		logic [31:0]      seq;
		logic [15:0]      prop;
		logic [31:0]      payload;
		logic             valid;
		logic             found;
		logic             evicted;
		logic [OCC_W-1:0] occ;
	} res_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] seq;
		logic [15:0] prop;
		logic [31:0] payload;
		logic        fixed;
		res_t        want;
	} drow_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [2:0]       operation;
	logic [31:0]      msg_seq;
	logic [15:0]      msg_prop;
	logic [31:0]      msg_payload;
	logic             done;
	logic [31:0]      out_seq;
	logic [15:0]      out_prop;
	logic [31:0]      out_payload;
	logic             out_valid;
	logic             found;
	logic             evicted;
	logic [OCC_W-1:0] occupancy;

	// sideband that travels with each item: typed-in expectation for directed rows
	logic pin_fixed;
	res_t pin_res;

	emrq_pkg::rec_t ring [DEPTH];
	int   q_front;
	int   q_rear;
	int   q_count;

	res_t        pending_q [$];
	logic [31:0] recent_seq [16];
	int          recent_n;
	int          sent_items;
	int          burst_left;
	int          checked;
	int          fail_count;
	int          evictions;
	int          search_hits;
	int          deep_sorts;

	drow_t plan [PLAN_LEN] = '{
		'{emrq_pkg::OP_POP, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{emrq_pkg::OP_PEEK, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{emrq_pkg::OP_SEARCH, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{emrq_pkg::OP_ROTATE, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{emrq_pkg::OP_SORT, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{emrq_pkg::OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd1}},
		'{emrq_pkg::OP_SORT, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd1}},
		'{emrq_pkg::OP_PEEK, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 5'd1}},
		'{emrq_pkg::OP_ENQ, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd2}},
		'{emrq_pkg::OP_ENQ, 32'h5555_5555, 16'h0001, 32'hAAAA_AAAA, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd3}},
		'{emrq_pkg::OP_SEARCH, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b1, 1'b0, 5'd3}},
		'{emrq_pkg::OP_SEARCH, 32'hFFFF_FFFF, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b1, 1'b0, 5'd3}},
		'{emrq_pkg::OP_SEARCH, 32'h1234_5678, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd3}},
		'{emrq_pkg::OP_SORT, 32'h0, 16'h0, 32'h0, 1'b0, '0},
		'{emrq_pkg::OP_PEEK, 32'h0, 16'h0, 32'h0, 1'b0, '0},
		'{emrq_pkg::OP_ROTATE, 32'h0, 16'h0, 32'h0, 1'b0, '0},
		'{emrq_pkg::OP_POP, 32'h0, 16'h0, 32'h0, 1'b0, '0},
		'{emrq_pkg::OP_POP, 32'h0, 16'h0, 32'h0, 1'b0, '0},
		'{emrq_pkg::OP_POP, 32'h0, 16'h0, 32'h0, 1'b0, '0},
		'{emrq_pkg::OP_POP, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{emrq_pkg::OP_ENQ, 32'hAAAA_AAAA, 16'h8000, 32'h5555_5555, 1'b0, '0},
		'{emrq_pkg::OP_CLEAR, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
		'{emrq_pkg::OP_PEEK, 32'h0, 16'h0, 32'h0, 1'b1,
			'{32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}}
	};

	evicting_message_ring_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.msg_seq    (msg_seq),
		.msg_prop   (msg_prop),
		.msg_payload(msg_payload),
		.done       (done),
		.out_seq    (out_seq),
		.out_prop   (out_prop),
		.out_payload(out_payload),
		.out_valid  (out_valid),
		.found      (found),
		.evicted    (evicted),
		.occupancy  (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t queue_apply(logic [2:0] op, logic [31:0] seq, logic [15:0] prop,
			logic [31:0] pay);
		res_t r;
		emrq_pkg::rec_t t;
		int pi;
		int pj;
		r = '0;
		case (op)
			emrq_pkg::OP_CLEAR: begin
				q_count = 0;
				q_front = 1;
				q_rear = 0;
			end
			emrq_pkg::OP_ENQ: begin
				if (q_count >= DEPTH) begin
					q_front = (q_front + 1) % DEPTH;
					q_count--;
					r.evicted = 1'b1;
				end
				q_rear = (q_rear + 1) % DEPTH;
				ring[q_rear] = '{seq: seq, prop: prop, payload: pay};
				q_count++;
			end
			emrq_pkg::OP_POP, emrq_pkg::OP_PEEK: begin
				if (q_count != 0) begin
					r.seq = ring[q_front].seq;
					r.prop = ring[q_front].prop;
					r.payload = ring[q_front].payload;
					r.valid = 1'b1;
					if (op == emrq_pkg::OP_POP) begin
						q_front = (q_front + 1) % DEPTH;
						q_count--;
					end
				end
			end
			emrq_pkg::OP_SORT: begin
				for (int a = 0; a + 1 < q_count; a++) begin
					for (int b = a + 1; b < q_count; b++) begin
						pi = (q_front + a) % DEPTH;
						pj = (q_front + b) % DEPTH;
						if (ring[pj].prop > ring[pi].prop) begin
							t = ring[pi];
							ring[pi] = ring[pj];
							ring[pj] = t;
						end
					end
				end
			end
			emrq_pkg::OP_ROTATE: begin
				if (q_count != 0) begin
					t = ring[q_front];
					q_front = (q_front + 1) % DEPTH;
					q_rear = (q_rear + 1) % DEPTH;
					ring[q_rear] = t;
				end
			end
			emrq_pkg::OP_SEARCH: begin
				for (int a = 0; a < q_count; a++)
					if (ring[(q_front + a) % DEPTH].seq == seq)
						r.found = 1'b1;
			end
			default: ;
		endcase
		r.occ = q_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic note_fail(input string what, input res_t want, input res_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s: exp seq=%h prop=%h pay=%h v=%b f=%b e=%b occ=%0d", what,
				want.seq, want.prop, want.payload, want.valid, want.found, want.evicted, want.occ);
			$display("%s: got seq=%h prop=%h pay=%h v=%b f=%b e=%b occ=%0d", what,
				got.seq, got.prop, got.payload, got.valid, got.found, got.evicted, got.occ);
		end
	endtask

	always @(posedge clk) begin : monitor
		res_t got;
		res_t calc;
		if (arst_n) begin
			if (done) begin
				got = '{out_seq, out_prop, out_payload, out_valid, found, evicted, occupancy};
				if (pending_q.size() == 0) begin
					note_fail("unexpected result", '0, got);
				end else begin
					checked++;
					if (got !== pending_q[0])
						note_fail("mismatch", pending_q[0], got);
					void'(pending_q.pop_front());
				end
			end
			if (start && !busy) begin
				if (operation == emrq_pkg::OP_SORT && q_count >= 2)
					deep_sorts++;
				calc = queue_apply(operation, msg_seq, msg_prop, msg_payload);
				evictions += calc.evicted;
				search_hits += calc.found;
				pending_q.push_back(pin_fixed ? pin_res : calc);
			end
		end
	end

	// hold the item until taken; a new burst begins after a random gap
	task automatic issue(input logic [2:0] op, input logic [31:0] seq, input logic [15:0] prop,
			input logic [31:0] pay, input logic fixed, input res_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		operation <= op;
		msg_seq <= seq;
		msg_prop <= prop;
		msg_payload <= pay;
		pin_fixed <= fixed;
		pin_res <= want;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
		if (op != OP_UNUSED)
			sent_items++;
		if (op == emrq_pkg::OP_ENQ) begin
			recent_seq[recent_n % 16] = seq;
			recent_n++;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [2:0]  op;
		logic [31:0] seq;
		logic [15:0] prop;
		int          pick;
		int          fill;
		int          rand_base;
		arst_n = 1'b0;
		start = 1'b0;
		operation = emrq_pkg::OP_CLEAR;
		msg_seq = '0;
		msg_prop = '0;
		msg_payload = '0;
		pin_fixed = 1'b0;
		pin_res = '0;
		q_front = 1;
		q_rear = 0;
		q_count = 0;
		recent_n = 0;
		sent_items = 0;
		burst_left = 0;
		checked = 0;
		fail_count = 0;
		evictions = 0;
		search_hits = 0;
		deep_sorts = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++)
			issue(plan[i].op, plan[i].seq, plan[i].prop, plan[i].payload, plan[i].fixed,
				plan[i].want);
		drain();

		rand_base = sent_items;
		while (sent_items - rand_base < RAND_ITEMS) begin
			if ($urandom_range(0, 2) != 0)
				issue(emrq_pkg::OP_CLEAR, $urandom, 16'($urandom), $urandom, 1'b0, '0);
			fill = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 10);
			repeat (fill + $urandom_range(5, 40)) begin
				pick = (fill > 0) ? 0 : $urandom_range(0, 99);
				if (fill > 0)
					fill--;
				case ($urandom_range(0, 3))
					0: seq = $urandom_range(0, 15);
					1: seq = ~32'($urandom_range(0, 3));
					default: seq = $urandom;
				endcase
				case ($urandom_range(0, 3))
					0: prop = 16'($urandom_range(0, 3));
					1: prop = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					default: prop = 16'($urandom_range(0, 65535));
				endcase
				if (pick < 30) op = emrq_pkg::OP_ENQ;
				else if (pick < 45) op = emrq_pkg::OP_POP;
				else if (pick < 55) op = emrq_pkg::OP_PEEK;
				else if (pick < 65) op = emrq_pkg::OP_SORT;
				else if (pick < 75) op = emrq_pkg::OP_ROTATE;
				else if (pick < 95) op = emrq_pkg::OP_SEARCH;
				else if (pick < 98) op = emrq_pkg::OP_CLEAR;
				else op = OP_UNUSED;
				if (op == emrq_pkg::OP_SEARCH && recent_n > 0 && $urandom_range(0, 1) == 1)
					seq = recent_seq[$urandom_range(0, (recent_n < 16 ? recent_n : 16) - 1)];
				issue(op, seq, prop, $urandom, 1'b0, '0);
			end
			if ($urandom_range(0, 3) == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_q.size() != 0)
			fail_count++;
		$display("ran %0d items, checked %0d results against the predicted queue", sent_items,
			checked);
		$display("saw %0d evictions, %0d search hits, %0d sorts over two or more records",
			evictions, search_hits, deep_sorts);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failures", fail_count);
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#(64'd30_000_000);
		$display("timeout with %0d results outstanding", pending_q.size());
		$display("status: fail");
		$finish;
	end

endmodule

>>> evicting_message_ring_queue_top.f
+incdir+hdl
hdl/emrq_pkg.sv
hdl/emrq_ram.sv
hdl/evicting_message_ring_queue_top.sv
hdl/emrq_checker.sv
sim/tb.sv
